// File: hw/rtl/tsched_pkg.sv
package tsched_pkg;

  localparam int MAX_TASKS_DEF = 32;
  localparam int ID_W          = 8;
  localparam int BURST_W       = 16;
  localparam int PRIO_W        = 8;
  localparam int MODE_W        = 2;
  localparam int CFG_W         = 16;
  localparam int CFG_IDX_W     = 1;
  localparam int IN_DATA_W     = 32;
  localparam int OUT_DATA_W    = 32;
  localparam logic [BURST_W-1:0] QUANTUM_RESET = 16'd10;

  typedef enum logic [MODE_W-1:0] {
    MODE_FCFS  = 2'd0,
    MODE_SJF   = 2'd1,
    MODE_PRIO  = 2'd2,
    MODE_RR    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_RAN    = 2'd0,
    STATUS_LOADED = 2'd1,
    STATUS_FULL   = 2'd2,
    STATUS_EMPTY  = 2'd3
  } status_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_NEXT = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLICY_MODE  = 1'b0,
    REG_TIME_QUANTUM = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK,
    ST_RR,
    ST_DROP,
    ST_SHIFT
  } state_t;

  typedef struct packed {
    logic [PRIO_W-1:0]  priority_val;
    logic [BURST_W-1:0] remaining;
    logic [ID_W-1:0]    id;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    status_t            status;
    logic [ID_W-1:0]    run_task;
    logic [BURST_W-1:0] run_length;
    logic               task_finished;
  } result_t;

endpackage

// File: hw/rtl/tsched_ram.sv
module tsched_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/tsched_min.sv
module tsched_min #(
  parameter int MAX_TASKS = tsched_pkg::MAX_TASKS_DEF
) (
  input  logic                         clk,
  input  tsched_pkg::mode_t            mode,
  input  logic                         smp_valid,
  input  logic                         smp_first,
  input  logic [$clog2(MAX_TASKS)-1:0] smp_idx,
  input  tsched_pkg::entry_t           smp_entry,
  output tsched_pkg::entry_t           best_entry,
  output logic [$clog2(MAX_TASKS)-1:0] best_idx
);

  logic better;

  always_comb begin
    case (mode)
      tsched_pkg::MODE_SJF:  better = smp_entry.remaining < best_entry.remaining;
      tsched_pkg::MODE_PRIO: better = smp_entry.priority_val < best_entry.priority_val;
      default:               better = 1'b0;
    endcase
  end

  // Strict compare keeps the earliest arrival on a tie.
  always_ff @(posedge clk) begin
    if (smp_valid && (smp_first || better)) begin
      best_entry <= smp_entry;
      best_idx   <= smp_idx;
    end
  end

endmodule

// File: hw/rtl/tsched_ctrl.sv
module tsched_ctrl #(
  parameter int MAX_TASKS = tsched_pkg::MAX_TASKS_DEF,
  localparam int AW = $clog2(MAX_TASKS),
  localparam int CW = $clog2(MAX_TASKS + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  tsched_pkg::op_t                     in_op,
  input  tsched_pkg::entry_t                  in_entry,
  input  tsched_pkg::mode_t                   mode,
  input  logic [tsched_pkg::BURST_W-1:0]      quantum,
  output logic                                res_valid,
  output tsched_pkg::result_t                 res,
  input  logic                                res_take,
  output logic                                ram_we,
  output logic [AW-1:0]                       ram_waddr,
  output tsched_pkg::entry_t                  ram_wdata,
  output logic [AW-1:0]                       ram_raddr,
  input  tsched_pkg::entry_t                  ram_rdata,
  output logic                                smp_valid,
  output logic                                smp_first,
  output logic [AW-1:0]                       smp_idx,
  input  tsched_pkg::entry_t                  best_entry,
  input  logic [AW-1:0]                       best_idx
);

  tsched_pkg::state_t  state, state_next;
  logic [CW-1:0]       fill, fill_next;
  logic [AW-1:0]       rot, rot_next;
  logic [AW-1:0]       iss_idx, iss_idx_next;
  logic                iss_done, iss_done_next;
  logic                rd_v, rd_v_next;
  logic [AW-1:0]       rd_idx, rd_idx_next;
  logic                rd_last, rd_last_next;
  logic [AW-1:0]       pick, pick_next;
  logic [AW-1:0]       sh_dst, sh_dst_next;
  logic                pend, pend_next;
  tsched_pkg::result_t res_q, res_next;

  logic [AW-1:0]                  last_idx;
  logic [AW-1:0]                  rr_start;
  logic [CW-1:0]                  fill_dec;
  logic [AW-1:0]                  rot_adj;
  logic [CW-1:0]                  rot_inc;
  logic [tsched_pkg::BURST_W-1:0] q_eff;

  assign in_ready  = (state == tsched_pkg::ST_IDLE) && !pend;
  assign res_valid = pend;
  assign res       = res_q;
  assign smp_valid = rd_v;
  assign smp_first = (rd_idx == '0);
  assign smp_idx   = rd_idx;

  assign last_idx = (mode == tsched_pkg::MODE_FCFS) ? '0 : AW'(fill - 1'b1);
  assign rr_start = (CW'(rot) >= fill) ? '0 : rot;
  assign fill_dec = fill - 1'b1;
  assign q_eff    = (quantum == '0) ? tsched_pkg::BURST_W'(1) : quantum;
  assign rot_inc  = CW'(rot) + 1'b1;

  always_comb begin
    rot_adj = (pick < rot) ? rot - 1'b1 : rot;
    if (CW'(rot_adj) >= fill_dec) begin
      rot_adj = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= tsched_pkg::ST_IDLE;
      fill     <= '0;
      rot      <= '0;
      iss_done <= 1'b0;
      rd_v     <= 1'b0;
      pend     <= 1'b0;
    end else begin
      state    <= state_next;
      fill     <= fill_next;
      rot      <= rot_next;
      iss_done <= iss_done_next;
      rd_v     <= rd_v_next;
      pend     <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    iss_idx <= iss_idx_next;
    rd_idx  <= rd_idx_next;
    rd_last <= rd_last_next;
    pick    <= pick_next;
    sh_dst  <= sh_dst_next;
    res_q   <= res_next;
  end

  always_comb begin
    state_next    = state;
    fill_next     = fill;
    rot_next      = rot;
    iss_idx_next  = iss_idx;
    iss_done_next = iss_done;
    rd_v_next     = 1'b0;
    rd_idx_next   = rd_idx;
    rd_last_next  = rd_last;
    pick_next     = pick;
    sh_dst_next   = sh_dst;
    pend_next     = pend && !res_take;
    res_next      = res_q;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = in_entry;
    ram_raddr     = '0;

    case (state)
      tsched_pkg::ST_IDLE: begin
        if (in_valid && in_ready) begin
          res_next  = '0;
          pend_next = 1'b1;
          if (in_op == tsched_pkg::OP_LOAD) begin
            if (fill == CW'(MAX_TASKS)) begin
              res_next.status = tsched_pkg::STATUS_FULL;
            end else begin
              ram_we          = 1'b1;
              ram_waddr       = AW'(fill);
              fill_next       = fill + 1'b1;
              res_next.status = tsched_pkg::STATUS_LOADED;
            end
          end else if (fill == '0) begin
            res_next.status = tsched_pkg::STATUS_EMPTY;
          end else if (mode == tsched_pkg::MODE_RR) begin
            pend_next  = 1'b0;
            rot_next   = rr_start;
            ram_raddr  = rr_start;
            state_next = tsched_pkg::ST_RR;
          end else begin
            pend_next     = 1'b0;
            ram_raddr     = '0;
            rd_v_next     = 1'b1;
            rd_idx_next   = '0;
            rd_last_next  = (last_idx == '0);
            iss_done_next = (last_idx == '0);
            iss_idx_next  = AW'(1);
            state_next    = tsched_pkg::ST_SCAN;
          end
        end
      end

      tsched_pkg::ST_SCAN: begin
        if (!iss_done) begin
          ram_raddr     = iss_idx;
          rd_v_next     = 1'b1;
          rd_idx_next   = iss_idx;
          rd_last_next  = (iss_idx == last_idx);
          iss_done_next = (iss_idx == last_idx);
          iss_idx_next  = iss_idx + 1'b1;
        end
        if (rd_v && rd_last) begin
          state_next = tsched_pkg::ST_PICK;
        end
      end

      tsched_pkg::ST_PICK: begin
        res_next.status        = tsched_pkg::STATUS_RAN;
        res_next.run_task      = best_entry.id;
        res_next.run_length    = best_entry.remaining;
        res_next.task_finished = 1'b1;
        pend_next              = 1'b1;
        pick_next              = best_idx;
        state_next             = tsched_pkg::ST_DROP;
      end

      tsched_pkg::ST_RR: begin
        res_next.status   = tsched_pkg::STATUS_RAN;
        res_next.run_task = ram_rdata.id;
        pend_next         = 1'b1;
        if (ram_rdata.remaining <= q_eff) begin
          res_next.run_length    = ram_rdata.remaining;
          res_next.task_finished = 1'b1;
          pick_next              = rot;
          state_next             = tsched_pkg::ST_DROP;
        end else begin
          res_next.run_length    = q_eff;
          res_next.task_finished = 1'b0;
          ram_we                 = 1'b1;
          ram_waddr              = rot;
          ram_wdata              = ram_rdata;
          ram_wdata.remaining    = ram_rdata.remaining - q_eff;
          rot_next               = (rot_inc >= fill) ? '0 : AW'(rot_inc);
          state_next             = tsched_pkg::ST_IDLE;
        end
      end

      tsched_pkg::ST_DROP: begin
        fill_next = fill_dec;
        rot_next  = rot_adj;
        if (CW'(pick) < fill_dec) begin
          ram_raddr   = pick + 1'b1;
          sh_dst_next = pick;
          state_next  = tsched_pkg::ST_SHIFT;
        end else begin
          state_next = tsched_pkg::ST_IDLE;
        end
      end

      tsched_pkg::ST_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = sh_dst;
        ram_wdata = ram_rdata;
        if (CW'(sh_dst) + 1'b1 == fill) begin
          state_next = tsched_pkg::ST_IDLE;
        end else begin
          ram_raddr   = sh_dst + AW'(2);
          sh_dst_next = sh_dst + 1'b1;
        end
      end

      default: begin
        state_next = tsched_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/task_run_scheduler_core.sv
// Task scheduler over a table of up to MAX_TASKS tasks held in arrival order in one
// single-port-read task memory. A first come first served pick reads only the head
// entry; shortest burst and priority picks read every held task once. Removing a task
// then shifts the later tasks down one entry a cycle through the same read port.
// Results leave through an output register, so the next word is taken while a result
// still waits on m_tready.
module task_run_scheduler_core #(
  parameter int MAX_TASKS = tsched_pkg::MAX_TASKS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // task_id [7:0], burst_time [23:8], task_priority [31:24]
  input  logic [tsched_pkg::IN_DATA_W-1:0]     s_tdata,
  // op [0]
  input  logic                                 s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // run_task [7:0], run_length [23:8], task_finished [24], zero [31:25]
  output logic [tsched_pkg::OUT_DATA_W-1:0]    m_tdata,
  // status [1:0]
  output logic [1:0]                           m_tuser,
  input  logic                                 cfg_we,
  input  logic [tsched_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tsched_pkg::CFG_W-1:0]         cfg_data
);

  localparam int AW = $clog2(MAX_TASKS);

  tsched_pkg::mode_t              mode;
  logic [tsched_pkg::BURST_W-1:0] quantum;
  tsched_pkg::entry_t             in_entry;
  tsched_pkg::result_t            res;
  logic                           res_valid;
  logic                           res_take;
  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [AW-1:0]                  ram_raddr;
  tsched_pkg::entry_t             ram_wdata;
  tsched_pkg::entry_t             ram_rdata;
  logic                           smp_valid;
  logic                           smp_first;
  logic [AW-1:0]                  smp_idx;
  tsched_pkg::entry_t             best_entry;
  logic [AW-1:0]                  best_idx;

  assign in_entry.id           = s_tdata[7:0];
  assign in_entry.remaining    = s_tdata[23:8];
  assign in_entry.priority_val = s_tdata[31:24];

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= tsched_pkg::MODE_FCFS;
      quantum <= tsched_pkg::QUANTUM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tsched_pkg::REG_POLICY_MODE:  mode    <= tsched_pkg::mode_t'(cfg_data[1:0]);
        tsched_pkg::REG_TIME_QUANTUM: quantum <= cfg_data;
        default: ;
      endcase
    end
  end

  assign res_take = res_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      m_tuser <= res.status;
      m_tdata <= {7'd0, res.task_finished, res.run_length, res.run_task};
    end
  end

  tsched_ram #(
    .WIDTH (tsched_pkg::ENTRY_W),
    .DEPTH (MAX_TASKS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tsched_min #(
    .MAX_TASKS (MAX_TASKS)
  ) u_min (
    .clk        (clk),
    .mode       (mode),
    .smp_valid  (smp_valid),
    .smp_first  (smp_first),
    .smp_idx    (smp_idx),
    .smp_entry  (ram_rdata),
    .best_entry (best_entry),
    .best_idx   (best_idx)
  );

  tsched_ctrl #(
    .MAX_TASKS (MAX_TASKS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_op      (tsched_pkg::op_t'(s_tuser)),
    .in_entry   (in_entry),
    .mode       (mode),
    .quantum    (quantum),
    .res_valid  (res_valid),
    .res        (res),
    .res_take   (res_take),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .smp_valid  (smp_valid),
    .smp_first  (smp_first),
    .smp_idx    (smp_idx),
    .best_entry (best_entry),
    .best_idx   (best_idx)
  );

endmodule
